// ----- sv/tli_pkg.sv -----
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants for the table linear interpolator: field widths,
// command and status codes, and the controller to datapath command and status
// groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tli_pkg;

  localparam int FX_W       = 32;
  localparam int IDX_IN_W   = 6;
  localparam int CNT_IN_W   = 7;
  localparam int ST_W       = 2;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 32;
  localparam int DIV_STEPS  = 32;
  localparam int DCNT_W     = 5;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [ST_W-1:0] ST_INTERP   = 2'd0;
  localparam logic [ST_W-1:0] ST_CLAMP_LO = 2'd1;
  localparam logic [ST_W-1:0] ST_CLAMP_HI = 2'd2;
  localparam logic [ST_W-1:0] ST_DEGEN    = 2'd3;

  typedef enum logic [2:0] {
    ADDR_ZERO,
    ADDR_ONE,
    ADDR_PROBE,
    ADDR_LAST,
    ADDR_IDX_M1,
    ADDR_IDX
  } addr_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RDY,
    RES_INTERP
  } res_sel_t;

  typedef struct packed {
    logic            wr;
    logic            load_q;
    logic            rd_en;
    addr_sel_t       rd_sel;
    logic            cap_lo;
    logic            cap_hi;
    logic            set_asc;
    logic            search_step;
    logic            diff;
    logic            mul_lo;
    logic            mul_hi;
    logic            mul_sum;
    logic            div_init;
    logic            div_step;
    logic            set_res;
    res_sel_t        res_sel;
    logic [ST_W-1:0] res_status;
    logic            push;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic count_zero;
    logic idx_zero;
    logic idx_end;
    logic out_busy;
  } dp_sts_t;

endpackage

// ----- sv/table_linear_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// table_linear_interpolator_unit
// A load transfer writes one breakpoint. An evaluate transfer on an empty
// table or on a single point skips the search; otherwise it runs P search
// probes and then clamps or interpolates. P is at most floor(log2(n)) + 1 for
// n breakpoints (P = 7 at 64 points). The breakpoint memories have one
// registered read port, so each probe is a read and then a compare; the
// interpolation is dominated by the 32-step restoring divider. The input is
// taken again once the result sits in the output register, so a stalled
// output delays only the next evaluate. The breakpoint table is not cleared
// by reset; point_count resets to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module table_linear_interpolator_unit import tli_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CNT_IN_W-1:0]   cfg_wdata,   // point_count
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // point_index, point_x, point_y, query_x
  input  logic [0:0]            in_tuser,    // command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // result_y
  output logic [ST_W-1:0]       out_tuser    // status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser[0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  tli_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .in_point_index (in_tdata[5:0]),
    .in_point_x     (in_tdata[37:6]),
    .in_point_y     (in_tdata[69:38]),
    .in_query_x     (in_tdata[101:70]),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_result_y   (out_tdata),
    .out_status     (out_tuser),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ----- sv/tli_ctrl.sv -----
// ----------------------------------------------------------------------------
// tli_ctrl
// Sequencer for the interpolator: table loads, the ascending check, the
// binary search probes, the fetch of the bracketing pair, multiply, divide
// and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tli_ctrl import tli_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    in_cmd,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_SINGLE,
    S_ASC0,
    S_ASC1,
    S_PROBE,
    S_CMP,
    S_PICK,
    S_CLAMP_LO,
    S_CLAMP_HI,
    S_FETCH0,
    S_FETCH1,
    S_DIFF,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_DIVINIT,
    S_DIV,
    S_FINISH,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [DCNT_W-1:0] div_cnt_r, div_cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    div_cnt_nxt    = div_cnt_r;
    cmd            = '0;
    cmd.rd_sel     = ADDR_ZERO;
    cmd.res_sel    = RES_ZERO;
    cmd.res_status = ST_DEGEN;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_cmd == CMD_EVAL) begin
            cmd.load_q = 1'b1;
            state_nxt  = S_START;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_START: begin
        if (sts.n_zero) begin
          cmd.set_res    = 1'b1;
          cmd.res_sel    = RES_ZERO;
          cmd.res_status = ST_DEGEN;
          state_nxt      = S_OUT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_ZERO;
          state_nxt  = sts.n_one ? S_SINGLE : S_ASC0;
        end
      end
      S_SINGLE: begin
        cmd.set_res    = 1'b1;
        cmd.res_sel    = RES_RDY;
        cmd.res_status = ST_DEGEN;
        state_nxt      = S_OUT;
      end
      S_ASC0: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_ONE;
        state_nxt  = S_ASC1;
      end
      S_ASC1: begin
        cmd.set_asc = 1'b1;
        state_nxt   = S_PROBE;
      end
      S_PROBE: begin
        if (sts.count_zero) begin
          state_nxt = S_PICK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_PROBE;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        cmd.search_step = 1'b1;
        state_nxt       = S_PROBE;
      end
      S_PICK: begin
        cmd.rd_en = 1'b1;
        if (sts.idx_zero) begin
          cmd.rd_sel = ADDR_ZERO;
          state_nxt  = S_CLAMP_LO;
        end else if (sts.idx_end) begin
          cmd.rd_sel = ADDR_LAST;
          state_nxt  = S_CLAMP_HI;
        end else begin
          cmd.rd_sel = ADDR_IDX_M1;
          state_nxt  = S_FETCH0;
        end
      end
      S_CLAMP_LO: begin
        cmd.set_res    = 1'b1;
        cmd.res_sel    = RES_RDY;
        cmd.res_status = ST_CLAMP_LO;
        state_nxt      = S_OUT;
      end
      S_CLAMP_HI: begin
        cmd.set_res    = 1'b1;
        cmd.res_sel    = RES_RDY;
        cmd.res_status = ST_CLAMP_HI;
        state_nxt      = S_OUT;
      end
      S_FETCH0: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_IDX;
        state_nxt  = S_FETCH1;
      end
      S_FETCH1: begin
        cmd.cap_hi = 1'b1;
        state_nxt  = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_sum = 1'b1;
        state_nxt   = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        div_cnt_nxt  = DCNT_W'(DIV_STEPS - 1);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          div_cnt_nxt = div_cnt_r - DCNT_W'(1);
        end
      end
      S_FINISH: begin
        cmd.set_res    = 1'b1;
        cmd.res_sel    = RES_INTERP;
        cmd.res_status = ST_INTERP;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.out_busy)
    else $error("result pushed while output register still full");

  a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_cmd == CMD_EVAL) |=> (state_r == S_START))
    else $error("evaluate transfer did not start the sequence");

  a_div_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_cnt_r == '0) |=> (cmd.set_res && cmd.res_sel == RES_INTERP))
    else $error("last divide step not followed by interpolated result");

endmodule

// ----- sv/tli_datapath.sv -----
// ----------------------------------------------------------------------------
// tli_datapath
// Breakpoint memories, search registers, shared 33x17 multiplier, restoring
// divider, saturation and the output register of the interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tli_datapath import tli_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wen,
  input  logic [CNT_IN_W-1:0] cfg_wdata,
  input  logic [IDX_IN_W-1:0] in_point_index,
  input  logic [FX_W-1:0]     in_point_x,
  input  logic [FX_W-1:0]     in_point_y,
  input  logic [FX_W-1:0]     in_query_x,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [FX_W-1:0]     out_result_y,
  output logic [ST_W-1:0]     out_status,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int EXT_W  = (CW > CNT_IN_W) ? CW : CNT_IN_W;
  localparam int SLOT_W = ((AW > IDX_IN_W) ? AW : IDX_IN_W) + 1;

  logic [FX_W-1:0] x_mem [MAX_POINTS];
  logic [FX_W-1:0] y_mem [MAX_POINTS];

  logic [CNT_IN_W-1:0] cnt_r;
  logic [CW-1:0]       n_r, first_r, count_r;
  logic [FX_W-1:0]     q_r, rd_x_r, rd_y_r, x_lo_r, y_lo_r, x_hi_r, y_hi_r;
  logic                asc_r, neg_r, ovf_r, dz_r;
  logic [32:0]         ma_r, mb_r, mden_r, rem_r;
  logic [49:0]         plo_r;
  logic [48:0]         phi_r;
  logic [64:0]         prod_r;
  logic [31:0]         dvd_r;
  logic [FX_W-1:0]     res_r;
  logic [ST_W-1:0]     st_r;
  logic                out_tvalid_r;
  logic [FX_W-1:0]     out_result_r;
  logic [ST_W-1:0]     out_status_r;

  logic [EXT_W-1:0]  cnt_ext;
  logic [CW-1:0]     n_new, step, probe;
  logic [SLOT_W-1:0] slot_ext;
  logic              slot_ok, beyond;
  logic [AW-1:0]     rd_addr;
  logic [32:0]       num_a, num_b, den;
  logic [16:0]       mul_b;
  logic [49:0]       mul_p;
  logic [65:0]       sum_w;
  logic [33:0]       shifted, sub_w;
  logic              ge;
  logic [31:0]       quot;
  logic [33:0]       acc_w;
  logic [FX_W-1:0]   sat_y;

  function automatic logic [32:0] mag33(input logic [32:0] v);
    mag33 = v[32] ? (~v + 33'd1) : v;
  endfunction

  assign cnt_ext  = EXT_W'(cnt_r);
  assign n_new    = (cnt_ext > EXT_W'(MAX_POINTS)) ? CW'(MAX_POINTS) : cnt_ext[CW-1:0];
  assign slot_ext = SLOT_W'(in_point_index);
  assign slot_ok  = (slot_ext < SLOT_W'(MAX_POINTS));

  assign step   = count_r >> 1;
  assign probe  = first_r + step;
  assign beyond = asc_r ? ($signed(rd_x_r) > $signed(q_r)) : ($signed(rd_x_r) <= $signed(q_r));

  always_comb begin
    case (cmd.rd_sel)
      ADDR_ZERO:   rd_addr = '0;
      ADDR_ONE:    rd_addr = AW'(1);
      ADDR_PROBE:  rd_addr = probe[AW-1:0];
      ADDR_LAST:   rd_addr = AW'(n_r - CW'(1));
      ADDR_IDX_M1: rd_addr = AW'(first_r - CW'(1));
      ADDR_IDX:    rd_addr = first_r[AW-1:0];
      default:     rd_addr = '0;
    endcase
  end

  assign num_a = {q_r[31], q_r} - {x_lo_r[31], x_lo_r};
  assign num_b = {y_hi_r[31], y_hi_r} - {y_lo_r[31], y_lo_r};
  assign den   = {x_hi_r[31], x_hi_r} - {x_lo_r[31], x_lo_r};

  assign mul_b = cmd.mul_hi ? {1'b0, mb_r[32:17]} : mb_r[16:0];
  assign mul_p = ma_r * mul_b;
  assign sum_w = {16'b0, plo_r} + {phi_r, 17'b0};

  assign shifted = {rem_r, dvd_r[31]};
  assign sub_w   = shifted - {1'b0, mden_r};
  assign ge      = (shifted >= {1'b0, mden_r});

  assign quot  = dz_r ? 32'd0 : (ovf_r ? 32'hFFFF_FFFF : dvd_r);
  assign acc_w = {{2{y_lo_r[31]}}, y_lo_r} + (neg_r ? (34'd0 - {2'b0, quot}) : {2'b0, quot});

  always_comb begin
    if (acc_w[33:31] == 3'b000 || acc_w[33:31] == 3'b111) begin
      sat_y = acc_w[31:0];
    end else if (acc_w[33]) begin
      sat_y = 32'h8000_0000;
    end else begin
      sat_y = 32'h7FFF_FFFF;
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (cmd.wr && slot_ok) begin
      x_mem[slot_ext[AW-1:0]] <= in_point_x;
      y_mem[slot_ext[AW-1:0]] <= in_point_y;
    end
    if (cmd.rd_en) begin
      rd_x_r <= x_mem[rd_addr];
      rd_y_r <= y_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_wen) begin
      cnt_r <= cfg_wdata;
    end
  end

  // search and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      q_r <= in_query_x;
      n_r <= n_new;
    end
    if (cmd.cap_lo) begin
      x_lo_r <= rd_x_r;
      y_lo_r <= rd_y_r;
    end
    if (cmd.cap_hi) begin
      x_hi_r <= rd_x_r;
      y_hi_r <= rd_y_r;
    end
    if (cmd.set_asc) begin
      asc_r   <= ($signed(rd_x_r) > $signed(x_lo_r));
      first_r <= '0;
      count_r <= n_r;
    end
    if (cmd.search_step) begin
      if (!beyond) begin
        first_r <= probe + CW'(1);
        count_r <= count_r - step - CW'(1);
      end else begin
        count_r <= step;
      end
    end
    if (cmd.diff) begin
      ma_r   <= mag33(num_a);
      mb_r   <= mag33(num_b);
      mden_r <= mag33(den);
      neg_r  <= num_a[32] ^ num_b[32] ^ den[32];
    end
    if (cmd.mul_lo) begin
      plo_r <= mul_p;
    end
    if (cmd.mul_hi) begin
      phi_r <= mul_p[48:0];
    end
    if (cmd.mul_sum) begin
      prod_r <= sum_w[64:0];
    end
    if (cmd.div_init) begin
      dz_r  <= (mden_r == '0);
      ovf_r <= (prod_r[64:32] >= mden_r);
      rem_r <= prod_r[64:32];
      dvd_r <= prod_r[31:0];
    end
    if (cmd.div_step) begin
      rem_r <= ge ? sub_w[32:0] : shifted[32:0];
      dvd_r <= {dvd_r[30:0], ge};
    end
    if (cmd.set_res) begin
      st_r <= cmd.res_status;
      case (cmd.res_sel)
        RES_ZERO:   res_r <= '0;
        RES_RDY:    res_r <= rd_y_r;
        RES_INTERP: res_r <= sat_y;
        default:    res_r <= '0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.push) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_result_r <= res_r;
      out_status_r <= st_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_result_y = out_result_r;
  assign out_status   = out_status_r;

  assign sts.n_zero     = (n_r == '0);
  assign sts.n_one      = (n_r == CW'(1));
  assign sts.count_zero = (count_r == '0);
  assign sts.idx_zero   = (first_r == '0);
  assign sts.idx_end    = (first_r >= n_r);
  assign sts.out_busy   = out_tvalid_r && !out_tready;

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.search_step |-> (({1'b0, first_r} + {1'b0, count_r}) <= {1'b0, n_r}))
    else $error("search window runs past the table");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && !ovf_r && !dz_r) |-> (rem_r < mden_r))
    else $error("divider remainder not below divisor");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(cmd.push))
    else $error("output valid raised without a push");

endmodule
